// ===== hdl/hyperedge_dedup_merge_table_macros.svh =====
// assertion helpers for the merge table
`ifndef HYPEREDGE_DEDUP_MERGE_TABLE_MACROS_SVH
`define HYPEREDGE_DEDUP_MERGE_TABLE_MACROS_SVH

// implication checked on every edge outside reset
`define HDM_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("hdm check failed");

// next-cycle implication checked outside reset
`define HDM_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("hdm check failed");

`endif

// ===== hdl/hdm_pkg.sv =====
`default_nettype none
package hdm_pkg;
   localparam int IdW = 16;

   typedef struct packed {
      logic [IdW-1:0] vertex_id;
      logic           vertex_flag;
      logic [31:0]    edge_weight;
      logic           last_vertex;
      logic           end_of_batch;
   } req_type;

   typedef struct packed {
      logic [7:0] edge_index;
      logic       matched;
      logic       dropped;
   } rsp_type;

   localparam logic [1:0] RuleAdd = 2'd0;
   localparam logic [1:0] RuleReplace = 2'd1;
   localparam logic [1:0] RuleDecay = 2'd2;
   localparam logic [15:0] DecayReset = 16'd58982;

   // saturate a 33-bit signed sum to 32 bits
   function automatic logic [31:0] sat33(input logic [32:0] v);
      if (v[32] != v[31]) begin
         sat33 = v[32] ? 32'h8000_0000 : 32'h7fff_ffff;
      end else begin
         sat33 = v[31:0];
      end
   endfunction
endpackage
`default_nettype wire

// ===== hdl/hyperedge_dedup_merge_table.sv =====
// Hyperedge merge table.
// The request channel carries one vertex per request (valid/ready); the
// request marked last_vertex completes an edge, and exactly that request
// produces one response on the rsp channel: the index of the matched or
// appended edge, a matched bit, or a dropped bit for an overlong edge or a
// full store. The psel/penable port is APB-style: register 0 update_rule at address 0,
// register 1 decay gain at address 4.
// Non-last vertices are only staged in the idle state. A last vertex is
// accepted, then runs a linear search: each visible stored edge passes
// StEdgeA, StEdgeB and StEdgeC for its two edge_start reads, and an edge of
// equal length adds a vertex memory read, then a compare, per compared vertex.
// Both memories have one port with a registered read. A miss then runs end of
// scan, table check, one append write per vertex and response; a match runs
// last compare, weight read, decay multiply, weight write and response.
// A drop runs the table check and response, after the scan if not overlong.
// Reset empties the table at once (counters cleared, no memory sweep) and
// restores update_rule 0 and the decay gain 58982. The response waits in an
// output register while rsp_ready is low; the block takes no request until it
// has been taken.
`default_nettype none
`include "hyperedge_dedup_merge_table_macros.svh"
module hyperedge_dedup_merge_table #(
   parameter int MAX_EDGES = 256,
   parameter int MAX_STORED_VERTICES = 2048,
   parameter int MAX_EDGE_ORDER = 8,
   parameter int VERTEX_ID_BITS = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire hdm_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output hdm_pkg::rsp_type      rsp_data,
   input  wire logic             psel,
   input  wire logic             penable,
   input  wire logic             pwrite,
   input  wire logic [2:0]       paddr,
   input  wire logic [31:0]      pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);
   import hdm_pkg::*;

   localparam int EW = $clog2(MAX_EDGES + 1);
   localparam int EIW = $clog2(MAX_EDGES);
   localparam int VW = $clog2(MAX_STORED_VERTICES + 1);
   localparam int VAW = $clog2(MAX_STORED_VERTICES);
   localparam int OW = $clog2(MAX_EDGE_ORDER + 1);
   localparam int SAW = (MAX_EDGE_ORDER > 1) ? $clog2(MAX_EDGE_ORDER) : 1;
   localparam int VIW = (VERTEX_ID_BITS < IdW) ? VERTEX_ID_BITS : IdW;
   localparam int SW = VIW + 1;

   localparam logic [3:0] StIdle = 4'd0;
   localparam logic [3:0] StEdgeA = 4'd1;
   localparam logic [3:0] StEdgeB = 4'd2;
   localparam logic [3:0] StEdgeC = 4'd3;
   localparam logic [3:0] StCmpRd = 4'd4;
   localparam logic [3:0] StCmpChk = 4'd5;
   localparam logic [3:0] StMiss = 4'd6;
   localparam logic [3:0] StAppend = 4'd7;
   localparam logic [3:0] StWRead = 4'd8;
   localparam logic [3:0] StWMul = 4'd9;
   localparam logic [3:0] StWWrite = 4'd10;
   localparam logic [3:0] StResp = 4'd11;

   // memories
   logic [SW-1:0] vmem [MAX_STORED_VERTICES];
   logic [VW-1:0] smem [MAX_EDGES + 1];
   logic [31:0]   wmem [MAX_EDGES];
   logic [SW-1:0] stg_ff [MAX_EDGE_ORDER];

   logic [3:0]     state_ff;
   logic [1:0]     rule_ff;
   logic [15:0]    decay_ff;
   logic [EW-1:0]  ecount_ff, vis_ff, e_ff;
   logic [VW-1:0]  vcount_ff, base_ff, s1_ff;
   logic [OW-1:0]  slen_ff, k_ff;
   logic           over_ff, eob_ff;
   logic [31:0]    w_ff, wst_ff;
   logic [47:0]    prod_ff;
   logic [SW-1:0]  vrd_ff;
   logic [VW-1:0]  srd_ff;
   logic [31:0]    wrd_ff;
   rsp_type        rsp_ff;
   logic           rspv_ff;

   // csr port
   assign pready = 1'b1;
   always_comb begin
      unique case (paddr[2])
         1'b0:    prdata = {30'd0, rule_ff};
         default: prdata = {16'd0, decay_ff};
      endcase
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         rule_ff <= RuleAdd;
         decay_ff <= DecayReset;
      end else if (psel && penable && pwrite) begin
         if (paddr == 3'd0) rule_ff <= pwdata[1:0];
         if (paddr == 3'd4) decay_ff <= pwdata[15:0];
      end
   end

   assign req_ready = (state_ff == StIdle) && !rspv_ff;
   assign rsp_valid = rspv_ff;
   assign rsp_data = rsp_ff;

   logic          acc;
   logic [SW-1:0] in_sym;
   assign acc = req_valid && req_ready;
   assign in_sym = {req_data.vertex_id[VIW-1:0], req_data.vertex_flag};

   // memory addresses driven by the sequencer
   logic [VAW-1:0] vaddr;
   logic [EW-1:0]  saddr;
   logic           vwe, swe;
   logic [VW-1:0]  swd;
   always_comb begin
      vaddr = VAW'(base_ff + VW'(k_ff));
      vwe = (state_ff == StAppend);
      saddr = e_ff;
      swe = 1'b0;
      swd = VW'(vcount_ff + VW'(slen_ff));
      unique case (state_ff)
         StEdgeA:  saddr = e_ff + EW'(1);
         StAppend: begin
            saddr = ecount_ff + EW'(1);
            swe = (k_ff == slen_ff - OW'(1));
         end
         default:  saddr = e_ff;
      endcase
   end

   // start of edge zero always reads as zero
   always_ff @(posedge clock) begin
      if (vwe) vmem[vaddr] <= stg_ff[SAW'(k_ff)];
      vrd_ff <= vmem[vaddr];
      if (swe) smem[saddr] <= swd;
      srd_ff <= (saddr == '0) ? '0 : smem[saddr];
   end

   // weight update arithmetic
   logic [47:0]  prod_c;
   logic [31:0]  dec_w, new_w;
   logic         wwe;
   assign prod_c = 48'($signed(wrd_ff) * $signed({1'b0, decay_ff}));
   assign dec_w = 32'((prod_ff + 48'd32768) >> 16);
   always_comb begin
      case (rule_ff)
         RuleReplace: new_w = w_ff;
         RuleDecay:   new_w = sat33({dec_w[31], dec_w} + {w_ff[31], w_ff});
         default:     new_w = sat33({wst_ff[31], wst_ff} + {w_ff[31], w_ff});
      endcase
   end
   assign wwe = (state_ff == StWWrite) ||
                (state_ff == StMiss && !over_ff && ecount_ff < EW'(MAX_EDGES) &&
                 ({1'b0, vcount_ff} + (VW+1)'(slen_ff)) <= (VW+1)'(MAX_STORED_VERTICES));
   always_ff @(posedge clock) begin
      if (wwe) wmem[EIW'(state_ff == StWWrite ? e_ff : ecount_ff)] <=
         (state_ff == StWWrite) ? new_w : w_ff;
      wrd_ff <= wmem[EIW'(e_ff)];
   end

   // staging buffer
   always_ff @(posedge clock) begin
      if (acc && slen_ff < OW'(MAX_EDGE_ORDER)) stg_ff[SAW'(slen_ff)] <= in_sym;
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
         ecount_ff <= '0;
         vis_ff <= '0;
         vcount_ff <= '0;
         slen_ff <= '0;
         over_ff <= 1'b0;
         rspv_ff <= 1'b0;
         e_ff <= '0;
         k_ff <= '0;
         base_ff <= '0;
      end else begin
         if (rspv_ff && rsp_ready) rspv_ff <= 1'b0;
         unique case (state_ff)
            StIdle: if (acc) begin
               if (slen_ff < OW'(MAX_EDGE_ORDER)) slen_ff <= slen_ff + OW'(1);
               else over_ff <= 1'b1;
               if (req_data.last_vertex) begin
                  w_ff <= req_data.edge_weight;
                  eob_ff <= req_data.end_of_batch;
                  e_ff <= '0;
                  k_ff <= '0;
                  state_ff <= (slen_ff >= OW'(MAX_EDGE_ORDER)) ? StMiss : StEdgeA;
               end
            end
            // read start of edge e (address e) and start of e+1
            StEdgeA: begin
               if (e_ff >= vis_ff) state_ff <= StMiss;
               else state_ff <= StEdgeB;
            end
            StEdgeB: begin
               s1_ff <= srd_ff;
               state_ff <= StEdgeC;
            end
            StEdgeC: begin
               base_ff <= srd_ff;
               k_ff <= '0;
               if (s1_ff - srd_ff == VW'(slen_ff)) state_ff <= StCmpRd;
               else begin
                  e_ff <= e_ff + EW'(1);
                  state_ff <= StEdgeA;
               end
            end
            StCmpRd: begin
               if (k_ff == slen_ff) state_ff <= StWRead;
               else state_ff <= StCmpChk;
            end
            StCmpChk: begin
               if (vrd_ff == stg_ff[SAW'(k_ff)]) begin
                  k_ff <= k_ff + OW'(1);
                  state_ff <= StCmpRd;
               end else begin
                  e_ff <= e_ff + EW'(1);
                  state_ff <= StEdgeA;
               end
            end
            StWRead: state_ff <= StWMul;
            StWMul: begin
               wst_ff <= wrd_ff;
               state_ff <= StWWrite;
            end
            StWWrite: begin
               rsp_ff <= '{edge_index: 8'(e_ff), matched: 1'b1, dropped: 1'b0};
               state_ff <= StResp;
            end
            StMiss: begin
               if (wwe) begin
                  base_ff <= vcount_ff;
                  k_ff <= '0;
                  rsp_ff <= '{edge_index: 8'(ecount_ff), matched: 1'b0, dropped: 1'b0};
                  state_ff <= StAppend;
               end else begin
                  rsp_ff <= '{edge_index: 8'd0, matched: 1'b0, dropped: 1'b1};
                  state_ff <= StResp;
               end
            end
            StAppend: begin
               k_ff <= k_ff + OW'(1);
               if (swe) begin
                  ecount_ff <= ecount_ff + EW'(1);
                  vcount_ff <= vcount_ff + VW'(slen_ff);
                  state_ff <= StResp;
               end
            end
            StResp: begin
               if (eob_ff) vis_ff <= (rsp_ff.dropped || rsp_ff.matched) ?
                  ecount_ff : ecount_ff;
               slen_ff <= '0;
               over_ff <= 1'b0;
               rspv_ff <= 1'b1;
               state_ff <= StIdle;
            end
            default: state_ff <= StIdle;
         endcase
      end
   end

   // decay product register (one multiply, registered)
   always_ff @(posedge clock) begin
      prod_ff <= prod_c;
   end

   `HDM_ASSERT_IMP(a_vis_le_count, 1'b1, vis_ff <= ecount_ff)
   `HDM_ASSERT_IMP(a_no_req_busy, state_ff != StIdle, !req_ready)
   `HDM_ASSERT_NEXT(a_resp_after, state_ff == StResp, rsp_valid)
   `HDM_ASSERT_IMP(a_resp_flags, rsp_valid, !(rsp_data.matched && rsp_data.dropped))
endmodule
`default_nettype wire
